// ===== sv/msb_pkg.sv =====
package msb_pkg;

  localparam int NUM_STACKS = 4;
  localparam int CAPACITY   = 64;
  localparam int DATA_W     = 32;
  localparam int SEL_W      = 2;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int SLOT_W     = $clog2(CAPACITY + 1);

  localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(CAPACITY);

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } msb_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } msb_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } msb_ctl_t;

endpackage

// ===== sv/msb_in_if.sv =====
interface msb_in_if
  import msb_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic [SEL_W-1:0]         stack_sel;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output cmd, output stack_sel, output push_value, input ready);
  modport sink   (input valid, input cmd, input stack_sel, input push_value, output ready);
endinterface

// ===== sv/msb_out_if.sv =====
interface msb_out_if
  import msb_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] pop_value;

  modport source (output valid, output ok, output pop_value, input ready);
  modport sink   (input valid, input ok, input pop_value, output ready);
endinterface

// ===== sv/multi_stack_shared_buffer.sv =====
// Four LIFO stacks sharing one 64-slot store threaded by a free list. At the
// transfer (ST_IDLE) each item looks up its slot (free-list head for a push,
// stack top for a pop) and reads its data and link from the shared stores,
// whose read data is registered; ST_EXEC, held while the result register is
// full and not taken, relinks the pointers, writes the stores and loads the
// result register. One result per item: ok is low for a push into a full
// store or a pop of an empty stack; pop_value is zero except on a good pop.
// New items are taken while a result waits. Ready from reset, no init pass.
module multi_stack_shared_buffer
  import msb_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  msb_in_if.sink  in_ch,
  msb_out_if.source out_ch
);

  msb_ctl_t ctl;

  msb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  msb_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .in_cmd        (in_ch.cmd),
    .in_stack_sel  (in_ch.stack_sel),
    .in_push_value (in_ch.push_value),
    .out_ok        (out_ch.ok),
    .out_pop_value (out_ch.pop_value)
  );

endmodule

// ===== sv/msb_ctrl.sv =====
module msb_ctrl
  import msb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output msb_ctl_t ctl
);

  msb_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    ctl.load      = 1'b0;
    ctl.exec      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // result register must be free or emptied by a transfer this cycle
        if (!out_valid_r || out_ready) begin
          ctl.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/msb_dp.sv =====
module msb_dp
  import msb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  msb_ctl_t                 ctl,
  input  logic                     in_cmd,
  input  logic [SEL_W-1:0]         in_stack_sel,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     out_ok,
  output logic signed [DATA_W-1:0] out_pop_value
);

  logic [DATA_W-1:0] data_mem [CAPACITY];
  logic [SLOT_W-1:0] link_mem [CAPACITY];
  logic [CAPACITY-1:0] link_vld_r, link_vld_nxt;

  logic [SLOT_W-1:0] heads_r [NUM_STACKS];
  logic [SLOT_W-1:0] heads_nxt [NUM_STACKS];
  logic [SLOT_W-1:0] free_head_r, free_head_nxt;

  logic              cmd_r;
  logic [SEL_W-1:0]  sel_r;
  logic [DATA_W-1:0] val_r;
  logic [SLOT_W-1:0] slot_r;
  logic [DATA_W-1:0] data_rd_r;
  logic [SLOT_W-1:0] link_rd_r;
  logic              link_vld_rd_r;
  logic              ok_r;
  logic [DATA_W-1:0] pop_value_r;

  logic              sel_in_ok;
  logic [SLOT_W-1:0] slot_sel;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              hit;
  logic [SLOT_W-1:0] link_val;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_link;

  // slot looked up at transfer: free head for push, top of stack for pop
  always_comb begin
    sel_in_ok = ({1'b0, in_stack_sel} < (SEL_W+1)'(NUM_STACKS));
    if (!sel_in_ok) begin
      slot_sel = SLOT_NONE;
    end else if (in_cmd == CMD_PUSH) begin
      slot_sel = free_head_r;
    end else begin
      slot_sel = heads_r[in_stack_sel];
    end
    rd_addr = slot_sel[ADDR_W-1:0];
  end

  always_comb begin
    hit      = (slot_r < SLOT_NONE);
    wr_addr  = slot_r[ADDR_W-1:0];
    // never-written link reads as its reset value: next slot, or none for the last
    link_val = link_vld_rd_r ? link_rd_r : slot_r + SLOT_W'(1);
    for (int i = 0; i < NUM_STACKS; i++) begin
      heads_nxt[i] = heads_r[i];
    end
    free_head_nxt = free_head_r;
    link_vld_nxt  = link_vld_r;
    wr_en         = 1'b0;
    wr_link       = free_head_r;
    if (ctl.exec && hit) begin
      wr_en                 = 1'b1;
      link_vld_nxt[wr_addr] = 1'b1;
      if (cmd_r == CMD_PUSH) begin
        free_head_nxt  = link_val;
        wr_link        = heads_r[sel_r];
        heads_nxt[sel_r] = slot_r;
      end else begin
        heads_nxt[sel_r] = link_val;
        wr_link          = free_head_r;
        free_head_nxt    = slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        heads_r[i] <= SLOT_NONE;
      end
      free_head_r <= '0;
      link_vld_r  <= '0;
    end else begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        heads_r[i] <= heads_nxt[i];
      end
      free_head_r <= free_head_nxt;
      link_vld_r  <= link_vld_nxt;
    end
  end

  // shared stores, read at transfer and written in ST_EXEC
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_rd_r     <= data_mem[rd_addr];
      link_rd_r     <= link_mem[rd_addr];
      link_vld_rd_r <= link_vld_r[rd_addr];
    end
    if (wr_en) begin
      link_mem[wr_addr] <= wr_link;
      if (cmd_r == CMD_PUSH) begin
        data_mem[wr_addr] <= val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_cmd;
      sel_r  <= in_stack_sel;
      val_r  <= DATA_W'(in_push_value);
      slot_r <= slot_sel;
    end
    if (ctl.exec) begin
      ok_r        <= hit;
      pop_value_r <= (hit && cmd_r == CMD_POP) ? data_rd_r : '0;
    end
  end

  assign out_ok        = ok_r;
  assign out_pop_value = signed'(pop_value_r);

endmodule

// ===== test/tb_multi_stack_shared_buffer.sv =====
module tb_multi_stack_shared_buffer;
  import msb_pkg::*;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] pop_value;
  } stack_result_t;

  logic clk;
  logic rst_n;

  msb_in_if  in_ch ();
  msb_out_if out_ch ();

  multi_stack_shared_buffer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow of the shared store, free list and stack tops
  logic signed [DATA_W-1:0] slot_data [CAPACITY];
  logic [SLOT_W-1:0]        slot_link [CAPACITY];
  logic [SLOT_W-1:0]        stack_top [NUM_STACKS];
  logic [SLOT_W-1:0]        free_top;
  int                       slots_in_use;

  stack_result_t expected_results [$];
  int            send_idle_pct;
  int            recv_idle_pct;
  int            mismatch_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_multi_stack_shared_buffer NOT OK");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void report_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endfunction

  function automatic void clear_stacks();
    for (int i = 0; i < CAPACITY; i++) begin
      slot_data[i] = '0;
      slot_link[i] = SLOT_W'(i + 1);
    end
    slot_link[CAPACITY-1] = SLOT_NONE;
    for (int s = 0; s < NUM_STACKS; s++) begin
      stack_top[s] = SLOT_NONE;
    end
    free_top     = '0;
    slots_in_use = 0;
  endfunction

  function automatic stack_result_t apply_stack_op(msb_op_t op, logic [SEL_W-1:0] sel,
                                                   logic signed [DATA_W-1:0] value);
    stack_result_t     res;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] idx;
    res = '0;
    if (int'(sel) >= NUM_STACKS) begin
      return res;
    end
    if (op == CMD_PUSH) begin
      slot = free_top;
      if (slot >= SLOT_NONE) begin
        return res;
      end
      idx            = slot[ADDR_W-1:0];
      free_top       = slot_link[idx];
      slot_data[idx] = value;
      slot_link[idx] = stack_top[sel];
      stack_top[sel] = slot;
      slots_in_use++;
      res.ok = 1'b1;
    end else begin
      slot = stack_top[sel];
      if (slot >= SLOT_NONE) begin
        return res;
      end
      idx            = slot[ADDR_W-1:0];
      stack_top[sel] = slot_link[idx];
      slot_link[idx] = free_top;
      free_top       = slot;
      slots_in_use--;
      res.ok        = 1'b1;
      res.pop_value = slot_data[idx];
    end
    return res;
  endfunction

  always @(posedge clk) begin : check_results
    stack_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_failure($sformatf("unexpected result: ok=%0b pop_value=%0d",
                                 out_ch.ok, out_ch.pop_value));
      end else begin
        want = expected_results.pop_front();
        if (out_ch.ok !== want.ok) begin
          report_failure($sformatf("ok: expected %0b, got %0b", want.ok, out_ch.ok));
        end
        if (out_ch.pop_value !== want.pop_value) begin
          report_failure($sformatf("pop_value: expected %0d, got %0d",
                                   want.pop_value, out_ch.pop_value));
        end
      end
    end
  end

  task automatic issue_op(msb_op_t op, logic [SEL_W-1:0] sel, logic signed [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= op;
    in_ch.stack_sel  <= sel;
    in_ch.push_value <= value;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    expected_results.push_back(apply_stack_op(op, sel, value));
  endtask

  task automatic wait_drained(int limit);
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic test_empty_pops();
    for (int s = 0; s < NUM_STACKS; s++) begin
      issue_op(CMD_POP, SEL_W'(s), $urandom);
    end
  endtask

  task automatic test_value_extremes();
    logic signed [DATA_W-1:0] extremes [5];
    extremes = '{32'sh7fffffff, 32'sh80000000, 32'sh00000000, 32'shffffffff, 32'sh55555555};
    for (int s = 0; s < NUM_STACKS; s++) begin
      issue_op(CMD_PUSH, SEL_W'(s), extremes[s]);
    end
    issue_op(CMD_PUSH, SEL_W'(0), extremes[4]);
    issue_op(CMD_PUSH, SEL_W'(0), 32'shaaaaaaaa);
    for (int s = NUM_STACKS - 1; s >= 0; s--) begin
      issue_op(CMD_POP, SEL_W'(s), $urandom);
    end
    issue_op(CMD_POP, SEL_W'(0), $urandom);
    issue_op(CMD_POP, SEL_W'(0), $urandom);
  endtask

  task automatic test_lifo_order();
    issue_op(CMD_PUSH, SEL_W'(2), $urandom);
    issue_op(CMD_PUSH, SEL_W'(2), $urandom);
    issue_op(CMD_PUSH, SEL_W'(1), $urandom);
    issue_op(CMD_PUSH, SEL_W'(2), $urandom);
    repeat (4) issue_op(CMD_POP, SEL_W'(2), $urandom);
    issue_op(CMD_POP, SEL_W'(1), $urandom);
  endtask

  // fill the whole store, push into it while full, then drain at random
  task automatic test_fill_and_drain();
    while (slots_in_use < CAPACITY) begin
      issue_op(CMD_PUSH, SEL_W'($urandom_range(NUM_STACKS - 1)), $urandom);
    end
    repeat (3) issue_op(CMD_PUSH, SEL_W'($urandom_range(NUM_STACKS - 1)), $urandom);
    while (slots_in_use != 0) begin
      issue_op(CMD_POP, SEL_W'($urandom_range(NUM_STACKS - 1)), $urandom);
    end
  endtask

  task automatic test_random_mix(int count);
    int      push_pct;
    msb_op_t op;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(3))
          0: push_pct = 30;
          1: push_pct = 50;
          2: push_pct = 70;
          default: push_pct = 90;
        endcase
      end
      op = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
      issue_op(op, SEL_W'($urandom_range(NUM_STACKS - 1)), $urandom);
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_PUSH;
    in_ch.stack_sel  = '0;
    in_ch.push_value = '0;
    rst_n            = 1'b0;
    mismatch_count   = 0;
    send_idle_pct    = 22;
    recv_idle_pct    = 66;
    clear_stacks();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_pops();
    test_value_extremes();
    test_lifo_order();
    test_fill_and_drain();
    wait_drained(100000);

    send_idle_pct = 66;
    recv_idle_pct = 22;
    test_random_mix(250);
    wait_drained(100000);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_fill_and_drain();
    test_random_mix(200);

    wait_drained(5000);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("tb_multi_stack_shared_buffer OK");
    end else begin
      $display("tb_multi_stack_shared_buffer NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/msb_pkg.sv
sv/msb_in_if.sv
sv/msb_out_if.sv
sv/msb_ctrl.sv
sv/msb_dp.sv
sv/multi_stack_shared_buffer.sv
test/tb_multi_stack_shared_buffer.sv
